### hdl/rcc_pkg.sv
// Shared types, constants and scaling functions of the RC channel conditioner.
package rcc_pkg;

  localparam int CHANNELS       = 8;
  localparam int AUX_FLAG_COUNT = 16;
  localparam int MAP_ENTRIES    = 5;

  localparam int CFG_ENTRIES = 5;
  localparam int IN_CHANNELS = 8;
  localparam int CHAN_W      = 12;
  localparam int STICK_W     = 10;
  localparam int FLAG_W      = 16;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 16;
  localparam int NORM_W      = 7;
  localparam int USED_W      = 3;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BIND = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [2:0] REG_MAP_ZERO  = 3'd0;
  localparam logic [2:0] REG_MAP_ONE   = 3'd1;
  localparam logic [2:0] REG_MAP_TWO   = 3'd2;
  localparam logic [2:0] REG_MAP_THREE = 3'd3;
  localparam logic [2:0] REG_MAP_FOUR  = 3'd4;
  localparam logic [2:0] REG_USED      = 3'd5;
  localparam logic [2:0] REG_TIMEOUT   = 3'd6;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000000;
  localparam logic [TIME_W-1:0] RATE_WINDOW   = 32'd1000000;

  typedef struct packed {
    logic [7:0] max_val;
    logic [7:0] min_val;
    logic [7:0] source;
    logic [7:0] target;
  } map_entry_t;

  typedef struct packed {
    map_entry_t [CFG_ENTRIES-1:0] entry;
    logic [USED_W-1:0]            used;
    logic [TIME_W-1:0]            timeout;
  } cfg_t;

  // Offset from 1500, clamped to +-500.
  function automatic logic signed [STICK_W-1:0] stick_scale(input logic [CHAN_W-1:0] raw);
    logic signed [CHAN_W:0] v;
    v = $signed({1'b0, raw}) - 13'sd1500;
    if (v < -13'sd500) v = -13'sd500;
    if (v > 13'sd500) v = 13'sd500;
    return v[STICK_W-1:0];
  endfunction

  // Offset from 1000, clamped to 0..1000.
  function automatic logic [STICK_W-1:0] throttle_scale(input logic [CHAN_W-1:0] raw);
    logic [STICK_W-1:0] v;
    if (raw <= 12'd1000) v = '0;
    else if (raw >= 12'd2000) v = 10'd1000;
    else v = 10'(raw - 12'd1000);
    return v;
  endfunction

  // 0..100 scale; divide by 10 as multiply by 205 and shift by 11 (exact below 1024).
  function automatic logic [NORM_W-1:0] aux_normalize(input logic [CHAN_W-1:0] raw);
    logic [9:0]  x;
    logic [17:0] p;
    logic [NORM_W-1:0] r;
    x = 10'(raw - 12'd1000);
    p = 18'(x) * 18'd205;
    if (raw <= 12'd1000) r = '0;
    else if (raw >= 12'd2000) r = 7'd100;
    else r = p[17:11];
    return r;
  endfunction

endpackage

### hdl/rc_channel_conditioner_unit.sv
// Top level of the RC channel conditioner: input stage, state update and result register.
//
//  channel   handshake                     payload
//  --------  ----------------------------  ----------------------------------------------
//  item      item_valid / item_ready       kind, now_us, chan_* (eight pulse widths)
//  result    result_valid / result_ready   roll/pitch/yaw/throttle_out, aux_flags,
//                                          failsafe_flag, bound_flag, packets_per_second
//  config    psel/penable/pwrite/pready    paddr (4*index), pwdata, prdata
//
// One transaction per cycle sustained while result_ready is held high; an accepted item passes
// through the input register, then the state/result register, before result_valid rises.
// The result register doubles as the conditioner state, so it only moves when the
// previous result has been taken; a stalled result_ready holds one item in the input
// register and then drops item_ready.
// Synchronous active-high reset restores all state: failsafe on, bind mode, counters 0.
module rc_channel_conditioner_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcc_pkg::ADDR_W-1:0]          paddr,
  input  logic [rcc_pkg::DATA_W-1:0]          pwdata,
  output logic [rcc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // item channel
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [1:0]                          kind,
  input  logic [rcc_pkg::TIME_W-1:0]          now_us,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_aileron,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_elevator,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_throttle,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_rudder,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_aux_one,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_aux_two,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_aux_three,
  input  logic [rcc_pkg::CHAN_W-1:0]          chan_aux_four,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [rcc_pkg::STICK_W-1:0]  roll_out,
  output logic signed [rcc_pkg::STICK_W-1:0]  pitch_out,
  output logic signed [rcc_pkg::STICK_W-1:0]  yaw_out,
  output logic [rcc_pkg::STICK_W-1:0]         throttle_out,
  output logic [rcc_pkg::FLAG_W-1:0]          aux_flags,
  output logic                                failsafe_flag,
  output logic                                bound_flag,
  output logic [rcc_pkg::COUNT_W-1:0]         packets_per_second
);

  rcc_pkg::cfg_t cfg;

  rcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                          s1_valid;
  logic [1:0]                    s1_kind;
  logic [rcc_pkg::TIME_W-1:0]    s1_now;
  logic [rcc_pkg::CHAN_W-1:0]    s1_chan [rcc_pkg::IN_CHANNELS];
  logic                          advance;
  logic                          item_take;

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;
  assign item_take  = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_kind    <= kind;
      s1_now     <= now_us;
      s1_chan[0] <= chan_aileron;
      s1_chan[1] <= chan_elevator;
      s1_chan[2] <= chan_throttle;
      s1_chan[3] <= chan_rudder;
      s1_chan[4] <= chan_aux_one;
      s1_chan[5] <= chan_aux_two;
      s1_chan[6] <= chan_aux_three;
      s1_chan[7] <= chan_aux_four;
    end
  end

  // ---------------------------------------------------------------------------
  // Conditioner state; the output fields are state registers themselves
  // ---------------------------------------------------------------------------
  logic [rcc_pkg::TIME_W-1:0]  last_packet_time;
  logic [rcc_pkg::COUNT_W-1:0] packet_counter;
  logic [rcc_pkg::TIME_W-1:0]  window_start;

  logic signed [rcc_pkg::STICK_W-1:0] roll_next, pitch_next, yaw_next;
  logic [rcc_pkg::STICK_W-1:0]        throttle_next;
  logic [rcc_pkg::FLAG_W-1:0]         aux_mapped, aux_next;
  logic                               failsafe_next, bound_next;
  logic [rcc_pkg::TIME_W-1:0]         last_next, window_next;
  logic [rcc_pkg::COUNT_W-1:0]        counter_next, rate_next;
  logic [rcc_pkg::NORM_W-1:0]         norm [rcc_pkg::IN_CHANNELS];
  logic                               is_data;
  logic [rcc_pkg::TIME_W-1:0]         silence, window_age;

  always_comb begin
    for (int c = 0; c < rcc_pkg::IN_CHANNELS; c++) begin
      norm[c] = rcc_pkg::aux_normalize(s1_chan[c]);
    end
  end

  rcc_aux_map u_aux_map (
    .cfg      (cfg),
    .norm     (norm),
    .aux_cur  (aux_flags),
    .aux_next (aux_mapped)
  );

  assign is_data = (s1_kind == rcc_pkg::KIND_DATA);

  always_comb begin
    // packet handling
    roll_next     = roll_out;
    pitch_next    = pitch_out;
    yaw_next      = yaw_out;
    throttle_next = throttle_out;
    aux_next      = aux_flags;
    failsafe_next = failsafe_flag;
    bound_next    = bound_flag;
    last_next     = last_packet_time;
    counter_next  = packet_counter;
    rate_next     = packets_per_second;
    window_next   = window_start;

    if (s1_kind == rcc_pkg::KIND_BIND) begin
      bound_next = 1'b1;
    end else if (is_data) begin
      bound_next    = 1'b1;
      roll_next     = rcc_pkg::stick_scale(s1_chan[0]);
      pitch_next    = rcc_pkg::stick_scale(s1_chan[1]);
      yaw_next      = rcc_pkg::stick_scale(s1_chan[3]);
      throttle_next = rcc_pkg::throttle_scale(s1_chan[2]);
      aux_next      = aux_mapped;
      counter_next  = packet_counter + 1'b1;
      last_next     = s1_now;
      failsafe_next = 1'b0;
    end

    // failsafe timer, modulo-2^32 elapsed time
    silence = s1_now - last_next;
    if (bound_next && !failsafe_next && (silence >= cfg.timeout)) begin
      failsafe_next = 1'b1;
      roll_next     = '0;
      pitch_next    = '0;
      yaw_next      = '0;
      throttle_next = '0;
    end

    // one-second rate window, closes when strictly exceeded
    window_age = s1_now - window_start;
    if (window_age > rcc_pkg::RATE_WINDOW) begin
      rate_next    = counter_next;
      counter_next = '0;
      window_next  = s1_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid       <= 1'b0;
      roll_out           <= '0;
      pitch_out          <= '0;
      yaw_out            <= '0;
      throttle_out       <= '0;
      aux_flags          <= '0;
      failsafe_flag      <= 1'b1;
      bound_flag         <= 1'b0;
      packets_per_second <= '0;
      last_packet_time   <= '0;
      packet_counter     <= '0;
      window_start       <= '0;
    end else if (advance) begin
      result_valid       <= 1'b1;
      roll_out           <= roll_next;
      pitch_out          <= pitch_next;
      yaw_out            <= yaw_next;
      throttle_out       <= throttle_next;
      aux_flags          <= aux_next;
      failsafe_flag      <= failsafe_next;
      bound_flag         <= bound_next;
      packets_per_second <= rate_next;
      last_packet_time   <= last_next;
      packet_counter     <= counter_next;
      window_start       <= window_next;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

### hdl/rcc_regs.sv
// Configuration register file behind the APB-style port.
module rcc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcc_pkg::ADDR_W-1:0] paddr,
  input  logic [rcc_pkg::DATA_W-1:0] pwdata,
  output logic [rcc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rcc_pkg::cfg_t              cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry   <= '0;
      cfg.used    <= '0;
      cfg.timeout <= rcc_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      case (index)
        rcc_pkg::REG_MAP_ZERO:  cfg.entry[0] <= pwdata;
        rcc_pkg::REG_MAP_ONE:   cfg.entry[1] <= pwdata;
        rcc_pkg::REG_MAP_TWO:   cfg.entry[2] <= pwdata;
        rcc_pkg::REG_MAP_THREE: cfg.entry[3] <= pwdata;
        rcc_pkg::REG_MAP_FOUR:  cfg.entry[4] <= pwdata;
        rcc_pkg::REG_USED:      cfg.used     <= pwdata[rcc_pkg::USED_W-1:0];
        rcc_pkg::REG_TIMEOUT:   cfg.timeout  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      rcc_pkg::REG_MAP_ZERO:  prdata = cfg.entry[0];
      rcc_pkg::REG_MAP_ONE:   prdata = cfg.entry[1];
      rcc_pkg::REG_MAP_TWO:   prdata = cfg.entry[2];
      rcc_pkg::REG_MAP_THREE: prdata = cfg.entry[3];
      rcc_pkg::REG_MAP_FOUR:  prdata = cfg.entry[4];
      rcc_pkg::REG_USED:      prdata = 32'(cfg.used);
      rcc_pkg::REG_TIMEOUT:   prdata = cfg.timeout;
      default:                prdata = '0;
    endcase
  end

endmodule

### hdl/rcc_aux_map.sv
// Aux flag mapping: walks the configured map entries, later entries win.
module rcc_aux_map (
  input  rcc_pkg::cfg_t                     cfg,
  input  logic [rcc_pkg::NORM_W-1:0]        norm [rcc_pkg::IN_CHANNELS],
  input  logic [rcc_pkg::FLAG_W-1:0]        aux_cur,
  output logic [rcc_pkg::FLAG_W-1:0]        aux_next
);

  logic [rcc_pkg::USED_W-1:0] used_sat;

  assign used_sat = (cfg.used > rcc_pkg::USED_W'(rcc_pkg::MAP_ENTRIES))
                  ? rcc_pkg::USED_W'(rcc_pkg::MAP_ENTRIES) : cfg.used;

  always_comb begin
    rcc_pkg::map_entry_t e;
    logic [rcc_pkg::NORM_W-1:0] val;
    aux_next = aux_cur;
    for (int i = 0; i < rcc_pkg::CFG_ENTRIES; i++) begin
      e   = cfg.entry[i];
      val = norm[e.source[2:0]];
      if ((i < rcc_pkg::MAP_ENTRIES) && (rcc_pkg::USED_W'(i) < used_sat)
          && (int'(e.source) < rcc_pkg::CHANNELS)
          && (int'(e.source) < rcc_pkg::IN_CHANNELS)
          && (int'(e.target) < rcc_pkg::AUX_FLAG_COUNT)
          && (int'(e.target) < rcc_pkg::FLAG_W)) begin
        aux_next[e.target[3:0]] = ({1'b0, val} >= e.min_val) && ({1'b0, val} <= e.max_val);
      end
    end
  end

endmodule
